// ===== hw/rtl/betd_pkg.sv =====
// ----------------------------------------------------------------------------
// betd_pkg
// Shared types and constants of the beat energy threshold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package betd_pkg;

    // samples in the derivative ring (difference spans RING_LENGTH-1 samples)
    localparam int RING_LENGTH = 5;
    localparam int FILL_W      = (RING_LENGTH > 2) ? $clog2(RING_LENGTH) : 1;

    // sample queue between byte front end and energy back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAT_THRESHOLD = 1'd1;

    localparam logic signed [15:0] THRESHOLD_RESET = 16'sd225;

    // byte order within a sample
    typedef enum logic {
        PH_LOW  = 1'b0,
        PH_HIGH = 1'b1
    } t_byte_phase;

    // sample handed from the front end to the queue
    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample;
    } t_sample_push;

    // queue status seen by the back end
    typedef struct packed {
        logic               empty;
        logic signed [15:0] head;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== hw/rtl/betd_front.sv =====
// ----------------------------------------------------------------------------
// betd_front
// Pairs received bytes (low then high) into signed 16-bit samples.
// ----------------------------------------------------------------------------
`default_nettype none

module betd_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire  [7:0]            i_rx_byte,
    input  wire                   i_q_full,
    output logic                  o_in_stall,
    output betd_pkg::t_sample_push o_push
);

    betd_pkg::t_byte_phase r_phase;
    logic [7:0]            r_low_half;
    logic                  w_accept;

    // hold off bytes while the queue has no room
    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // phase and low byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= betd_pkg::PH_LOW;
            r_low_half <= 8'd0;
        end else if (w_accept) begin
            if (r_phase == betd_pkg::PH_LOW) begin
                r_low_half <= i_rx_byte;
                r_phase    <= betd_pkg::PH_HIGH;
            end else begin
                r_phase <= betd_pkg::PH_LOW;
            end
        end
    end

    // a completed sample goes to the queue with its high byte
    always_comb begin
        o_push.valid  = w_accept && (r_phase == betd_pkg::PH_HIGH);
        o_push.sample = {i_rx_byte, r_low_half};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/betd_queue.sv =====
// ----------------------------------------------------------------------------
// betd_queue
// Short sample queue that decouples the byte front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module betd_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  betd_pkg::t_sample_push  i_push,
    input  wire                     i_pop,
    output logic                    o_full,
    output betd_pkg::t_queue_status o_status
);

    logic signed [15:0]          r_mem [betd_pkg::QUEUE_DEPTH];
    logic [betd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [betd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [betd_pkg::QCNT_W-1:0] r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_full          = (r_count == betd_pkg::QCNT_W'(betd_pkg::QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.head   = r_mem[r_rd_ptr];
    assign w_push          = i_push.valid && !o_full;
    assign w_pop           = i_pop && !o_status.empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.sample;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == betd_pkg::QPTR_W'(betd_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == betd_pkg::QPTR_W'(betd_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/betd_back.sv =====
// ----------------------------------------------------------------------------
// betd_back
// Derivative, square, leaky energy sum and rising threshold crossing.
// Two stages: square, then sum/compare into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module betd_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  betd_pkg::t_queue_status i_status,
    output logic                    o_pop,
    input  wire                     i_energy_mode,
    input  wire  signed [15:0]      i_beat_threshold,
    input  wire                     i_out_stall,
    output logic                    o_out_valid,
    output logic signed [15:0]      o_level,
    output logic                    o_beat,
    output logic [15:0]             o_beat_count
);

    localparam int OLD_TAP = betd_pkg::RING_LENGTH - 2;

    // ring of the last RING_LENGTH-1 energy-mode samples
    logic signed [15:0]          r_ring [betd_pkg::RING_LENGTH-1];
    logic [betd_pkg::FILL_W-1:0] r_fill;

    // stage a
    logic                        r_a_valid;
    logic                        r_a_energy;
    logic signed [15:0]          r_a_sample;
    logic [15:0]                 r_a_sq;

    // stage b state
    logic [15:0]                 r_sum;
    logic signed [15:0]          r_prev_level;

    logic                        w_out_free;
    logic                        w_b_move;
    logic                        w_a_free;
    logic                        w_energy_in;
    logic                        w_filled;
    logic signed [16:0]          w_diff;
    logic signed [16:0]          w_diff_sh;
    logic [13:0]                 w_abs;
    logic [27:0]                 w_sq_full;
    logic [15:0]                 n_sum;
    logic signed [15:0]          n_level;
    logic                        n_beat;

    // handshake between stages
    assign w_out_free  = !o_out_valid || !i_out_stall;
    assign w_b_move    = r_a_valid && w_out_free;
    assign w_a_free    = !r_a_valid || w_b_move;
    assign o_pop       = w_a_free && !i_status.empty;
    assign w_energy_in = o_pop && i_energy_mode;

    // derivative over the ring, arithmetic shift, magnitude, square
    always_comb begin
        w_filled  = (r_fill == betd_pkg::FILL_W'(betd_pkg::RING_LENGTH - 1));
        w_diff    = w_filled ? (17'(i_status.head) - 17'(r_ring[OLD_TAP])) : 17'sd0;
        w_diff_sh = w_diff >>> 3;
        w_abs     = w_diff_sh[16] ? 14'(-w_diff_sh) : 14'(w_diff_sh);
        w_sq_full = w_abs * w_abs;
    end

    // ring shift line and fill count, held in pass mode
    always_ff @(posedge i_clk) begin
        if (w_energy_in) begin
            r_ring[0] <= i_status.head;
            for (int i = 1; i < betd_pkg::RING_LENGTH - 1; i++) begin
                r_ring[i] <= r_ring[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_energy_in && !w_filled) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // stage a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= !i_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_energy <= i_energy_mode;
            r_a_sample <= i_status.head;
            r_a_sq     <= w_sq_full[15:0];
        end
    end

    // leaky sum and crossing test
    always_comb begin
        n_sum   = r_sum + {4'd0, r_a_sq[15:4]} - {3'd0, r_sum[15:3]};
        n_level = r_a_energy ? $signed(n_sum) : r_a_sample;
        n_beat  = (n_level >= i_beat_threshold) && (r_prev_level < i_beat_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_prev_level <= '0;
            o_beat_count <= '0;
        end else if (w_b_move) begin
            if (r_a_energy) begin
                r_sum <= n_sum;
            end
            r_prev_level <= n_level;
            if (n_beat) begin
                o_beat_count <= o_beat_count + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_free) begin
            o_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            o_level <= n_level;
            o_beat  <= n_beat;
        end
    end

    // checks
    a_beat_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_move && n_beat) |=> (o_beat_count == $past(o_beat_count) + 16'd1))
        else $error("beat count did not advance on a beat");

    a_pass_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_move && !r_a_energy) |=> (o_level == $past(r_a_sample)))
        else $error("pass mode level differs from sample");

    a_pass_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_move && !r_a_energy) |=> $stable(r_sum))
        else $error("energy sum moved in pass mode");

    a_no_pop_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_b_move) |-> !o_pop)
        else $error("sample taken while stage a is held");

endmodule

`default_nettype wire

// ===== hw/rtl/beat_energy_threshold_detector_core.sv =====
// ----------------------------------------------------------------------------
// beat_energy_threshold_detector_core
// Byte-fed beat detector: derivative energy or raw sample against a threshold.
// ----------------------------------------------------------------------------
// Takes one byte per clock while not stalled; every second byte (the high
// half) completes a signed 16-bit sample and gives one result (level, beat
// flag, beat count). A sample goes through a two-entry queue, a square stage
// and a sum/compare stage into the output register; the back end takes one
// sample per cycle while the output is not stalled, and the leaky-sum
// recurrence closes within the sum/compare stage. Stalls on the output fill
// the queue, after which bytes are stalled. Configuration (mode, threshold) is
// for the user to write only while idle; the block does not enforce it.
`default_nettype none

module beat_energy_threshold_detector_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    input  wire  [7:0]                        i_rx_byte,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output logic signed [15:0]                o_level,
    output logic                              o_beat,
    output logic [15:0]                       o_beat_count,
    input  wire                               i_out_stall,
    input  wire                               i_cfg_we,
    input  wire  [betd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [15:0]                       i_cfg_data
);

    logic                    r_energy_mode;
    logic signed [15:0]      r_beat_threshold;
    logic                    w_q_full;
    logic                    w_pop;
    betd_pkg::t_sample_push  w_push;
    betd_pkg::t_queue_status w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_mode    <= 1'b0;
            r_beat_threshold <= betd_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                betd_pkg::CFG_ENERGY_MODE:    r_energy_mode    <= i_cfg_data[0];
                betd_pkg::CFG_BEAT_THRESHOLD: r_beat_threshold <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // byte pairing
    betd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push)
    );

    // sample queue
    betd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_full   (w_q_full),
        .o_status (w_status)
    );

    // energy and beat logic
    betd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_status         (w_status),
        .o_pop            (w_pop),
        .i_energy_mode    (r_energy_mode),
        .i_beat_threshold (r_beat_threshold),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_level          (o_level),
        .o_beat           (o_beat),
        .o_beat_count     (o_beat_count)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the beat energy threshold detector core.
// ----------------------------------------------------------------------------
// Bytes go in on the valid/stall input channel. Every accepted byte also goes
// to an in-bench copy of the detector: byte pairing, the energy ring with its
// leaky sum, and the threshold crossing with its beat counter. Every high byte
// queues the level, beat flag and count that the block should send back.
// Results leaving the block are checked field by field against the oldest
// queued expectation. The input idles and the output stalls at random. Mode and
// threshold are rewritten between phases once the block has drained.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_BYTES  = 670;
    localparam int CYCLE_LIMIT   = 600000;

    // sample shapes for the random phases
    typedef enum {WAVE_WIDE, WAVE_QUIET, WAVE_SPIKES, WAVE_RAILS} t_wave;

    typedef struct {
        logic signed [15:0] level;
        logic               beat;
        logic [15:0]        count;
    } t_beat_result;

    // expected-level store and detector copy
    class beat_scoreboard;
        logic                  energy_mode;
        logic signed [15:0]    threshold;
        betd_pkg::t_byte_phase phase;
        logic [7:0]            low_half;
        logic signed [15:0]    ring [betd_pkg::RING_LENGTH];
        int                    ring_pos;
        logic                  ring_full;
        logic [15:0]           energy_sum;
        logic signed [15:0]    prev_level;
        logic [15:0]           beats;
        t_beat_result          expected_levels [$];
        int                    error_count;

        function new();
            energy_mode = 1'b0;
            threshold   = betd_pkg::THRESHOLD_RESET;
            phase       = betd_pkg::PH_LOW;
            low_half    = '0;
            foreach (ring[k]) ring[k] = '0;
            ring_pos    = 0;
            ring_full   = 1'b0;
            energy_sum  = '0;
            prev_level  = '0;
            beats       = '0;
            error_count = 0;
        endfunction

        function void set_config(logic [betd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == betd_pkg::CFG_ENERGY_MODE) begin
                energy_mode = data[0];
            end else if (idx == betd_pkg::CFG_BEAT_THRESHOLD) begin
                threshold = data;
            end
        endfunction

        // derivative over the ring, squared, into the leaky sum
        function logic signed [15:0] energy_step(logic signed [15:0] s);
            int                 newest;
            int                 oldest;
            logic signed [16:0] delta;
            logic signed [16:0] slope;
            int                 mag;
            logic [15:0]        sq;
            ring[ring_pos] = s;
            ring_pos++;
            if (ring_pos == betd_pkg::RING_LENGTH) begin
                ring_pos  = 0;
                oldest    = 0;
                newest    = betd_pkg::RING_LENGTH - 1;
                ring_full = 1'b1;
            end else begin
                oldest = ring_pos;
                newest = ring_pos - 1;
            end
            slope = '0;
            if (ring_full) begin
                delta = ring[newest] - ring[oldest];
                slope = delta >>> 3;
            end
            mag = (slope < 0) ? -int'(slope) : int'(slope);
            sq  = 16'(mag * mag);
            energy_sum = energy_sum + (sq >> 4) - (energy_sum >> 3);
            return energy_sum;
        endfunction

        // accepted input byte: the high half completes a sample
        function void note_byte(logic [7:0] b);
            logic signed [15:0] sample;
            t_beat_result       res;
            if (phase == betd_pkg::PH_LOW) begin
                low_half = b;
                phase    = betd_pkg::PH_HIGH;
                return;
            end
            phase     = betd_pkg::PH_LOW;
            sample    = {b, low_half};
            res.level = energy_mode ? energy_step(sample) : sample;
            res.beat  = (res.level >= threshold) && (prev_level < threshold);
            if (res.beat) beats++;
            res.count  = beats;
            prev_level = res.level;
            expected_levels.push_back(res);
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            error_count++;
        endtask

        task check_result(logic signed [15:0] level, logic beat, logic [15:0] count);
            t_beat_result want;
            if (expected_levels.size() == 0) begin
                report($sformatf("result with nothing expected: level %0d", level));
                return;
            end
            want = expected_levels.pop_front();
            if (level !== want.level)
                report($sformatf("level got %0d want %0d", level, want.level));
            if (beat !== want.beat)
                report($sformatf("beat got %0b want %0b", beat, want.beat));
            if (count !== want.count)
                report($sformatf("beat_count got %0d want %0d", count, want.count));
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic [7:0]                     i_rx_byte;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic signed [15:0]             o_level;
    logic                           o_beat;
    logic [15:0]                    o_beat_count;
    logic                           i_out_stall;
    logic                           i_cfg_we;
    logic [betd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]                    i_cfg_data;

    beat_scoreboard sb = new();
    bit             quiet = 1'b0;
    int             cycle_count = 0;
    int             bytes_sent = 0;

    beat_energy_threshold_detector_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_level      (o_level),
        .o_beat       (o_beat),
        .o_beat_count (o_beat_count),
        .i_out_stall  (i_out_stall),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // cycle counter and run limit
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // input beats feed the detector copy
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_byte(i_rx_byte);
    end

    // output beats get checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_level, o_beat, o_beat_count);
    end

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver stall pattern
    initial begin
        int len;
        forever begin
            len = pick_gap();
            if (len > 0) begin
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    task send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task send_sample(input logic [15:0] s);
        send_byte(s[7:0]);
        send_byte(s[15:8]);
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_cfg(input logic [betd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_config(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] draw_sample(t_wave wave);
        int r;
        r = $urandom_range(0, 99);
        case (wave)
            WAVE_WIDE:   return 16'($urandom);
            WAVE_QUIET:  return 16'($urandom_range(0, 600)) - 16'd300;
            WAVE_SPIKES: begin
                if (r < 15)
                    return $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 8000))
                                                : 16'h8000 + 16'($urandom_range(0, 8000));
                return 16'($urandom_range(0, 200)) - 16'd100;
            end
            default: begin
                if (r < 40) return 16'h7FFF;
                if (r < 80) return 16'h8000;
                return (r < 90) ? 16'h0000 : 16'hFFFF;
            end
        endcase
    endfunction

    initial begin
        logic        mode;
        logic [15:0] thr;
        t_wave       wave;
        int          nsamp;
        int          phase_idx;
        int          stop_at;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= betd_pkg::CFG_ENERGY_MODE;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass mode at reset threshold: exact hit, one below, rails
        send_sample(16'h0000);
        send_sample(16'h00E1);
        send_sample(16'h00E0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h00E1);
        drain();

        // energy mode from an empty ring with full-scale swings
        write_cfg(betd_pkg::CFG_ENERGY_MODE, 16'd1);
        write_cfg(betd_pkg::CFG_BEAT_THRESHOLD, 16'd1);
        repeat (3) begin
            send_sample(16'h8000);
            send_sample(16'h7FFF);
        end
        drain();

        // random phases, each with its own mode and threshold
        phase_idx = 0;
        stop_at   = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (phase_idx == 0) begin
                mode = 1'b0;
                thr  = 16'h8000;
            end else if (phase_idx == 1) begin
                mode = 1'b1;
                thr  = 16'h7FFF;
            end else begin
                mode = 1'($urandom_range(0, 1));
                if (mode)
                    thr = 16'($urandom_range(0, 4000));
                else
                    thr = $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'($urandom_range(0, 600)) - 16'd300;
            end
            write_cfg(betd_pkg::CFG_ENERGY_MODE, {15'd0, mode});
            write_cfg(betd_pkg::CFG_BEAT_THRESHOLD, thr);

            wave  = t_wave'($urandom_range(0, 3));
            nsamp = $urandom_range(15, 40);
            repeat (nsamp) begin
                // some spread within a phase so no shape runs alone
                if ($urandom_range(0, 9) == 0)
                    send_sample(draw_sample(t_wave'($urandom_range(0, 3))));
                else
                    send_sample(draw_sample(wave));
            end
            // now and then a lone low byte carries into the next phase
            if ($urandom_range(0, 5) == 0) send_byte(8'($urandom));
            drain();
            phase_idx++;
        end

        quiet = 1'b0;
        drain();
        if (sb.pending() > 0) sb.report($sformatf("%0d results never came", sb.pending()));
        if (sb.error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/betd_pkg.sv
hw/rtl/betd_front.sv
hw/rtl/betd_queue.sv
hw/rtl/betd_back.sv
hw/rtl/beat_energy_threshold_detector_core.sv
tb/sv/tb_top.sv
